[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ALE_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define ALE_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/ale_pkg.sv]
// shared types, codes and constants of the array list engine
package ale_pkg;

   // built configuration defaults
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // port field widths
   localparam int MODE_W     = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [LEN_W-1:0]     CAP_RESET    = 7'd64;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND  = 3'd0,
      MODE_INSERT  = 3'd1,
      MODE_REMOVE  = 3'd2,
      MODE_REVERSE = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_LOOP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_REM_LOOP,
      ST_REV_RD_A,
      ST_REV_RD_B,
      ST_REV_WR_A,
      ST_REV_WR_B,
      ST_SCAN_START,
      ST_SCAN_RUN,
      ST_SCAN_DRAIN,
      ST_FINISH
   } state_type;

   // memory read address select
   typedef enum logic [2:0] {
      RA_IDX,
      RA_IDX_DN,
      RA_IDX_DN2,
      RA_IDX_UP,
      RA_IDX_UP2,
      RA_JDX
   } rd_sel_type;

   // memory write address select
   typedef enum logic [1:0] {
      WA_COUNT,
      WA_IDX,
      WA_JDX,
      WA_POS
   } wa_sel_type;

   // memory write data select
   typedef enum logic [1:0] {
      WD_VALUE,
      WD_RDATA,
      WD_TMP
   } wd_sel_type;

   // pointer and length updates
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      JDX_HOLD,
      JDX_LAST,
      JDX_DEC
   } jdx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ld;
      logic       status_ld;
      status_type status_val;
      logic       wr_en;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      rd_sel_type rd_sel;
      idx_op_type idx_op;
      jdx_op_type jdx_op;
      cnt_op_type cnt_op;
      logic       tmp_ld;
      logic       ext_init;
      logic       scan_rd;
      logic       out_ld;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              pos_ok;
      logic              has_room;
      logic              cnt_le1;
      logic              rem_direct;
      logic              ins_last;
      logic              rem_last;
      logic              rev_more;
      logic              scan_last;
      logic              cnt_zero;
      logic              out_free;
   } dp_stat_type;

endpackage

[sv/ale_ram.sv]
// generic single-port-write memory with registered read
module ale_ram #(
   parameter int WIDTH = ale_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH = ale_pkg::CAPACITY_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ale_ctrl.sv]
// sequencing state machine of the array list engine
module ale_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ale_pkg::dp_stat_type stat,
   output ale_pkg::ctrl_cmd_type cmd
);
   import ale_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // only idle takes a request
   assign req_stall = reset || (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_ld = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.status_ld  = 1'b1;
            cmd.status_val = STAT_DONE;
            state_in       = ST_SCAN_START;
            unique case (stat.mode)
               MODE_APPEND: begin
                  if (stat.has_room) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wa_sel = WA_COUNT;
                     cmd.wd_sel = WD_VALUE;
                     cmd.cnt_op = CNT_INC;
                  end else begin
                     cmd.status_val = STAT_FULL;
                  end
               end
               MODE_INSERT: begin
                  if (!stat.pos_ok) begin
                     cmd.status_val = STAT_RANGE;
                  end else if (!stat.has_room) begin
                     cmd.status_val = STAT_FULL;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = ST_INS_RD;
                  end
               end
               MODE_REMOVE: begin
                  if (!stat.pos_ok) begin
                     cmd.status_val = STAT_RANGE;
                  end else if (stat.rem_direct) begin
                     cmd.cnt_op = CNT_DEC;
                  end else begin
                     cmd.idx_op = IDX_POS;
                     state_in   = ST_REM_RD;
                  end
               end
               MODE_REVERSE: begin
                  if (!stat.cnt_le1) begin
                     cmd.idx_op = IDX_ZERO;
                     cmd.jdx_op = JDX_LAST;
                     state_in   = ST_REV_RD_A;
                  end
               end
               MODE_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               default: begin
                  state_in = ST_SCAN_START;
               end
            endcase
         end
         // shift up, top entry first
         ST_INS_RD: begin
            cmd.rd_sel = RA_IDX_DN;
            state_in   = ST_INS_LOOP;
         end
         ST_INS_LOOP: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            cmd.rd_sel = RA_IDX_DN2;
            cmd.idx_op = IDX_DEC;
            if (stat.ins_last) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.wd_sel = WD_VALUE;
            cmd.cnt_op = CNT_INC;
            state_in   = ST_SCAN_START;
         end
         // shift down, from the removed position
         ST_REM_RD: begin
            cmd.rd_sel = RA_IDX_UP;
            state_in   = ST_REM_LOOP;
         end
         ST_REM_LOOP: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            cmd.rd_sel = RA_IDX_UP2;
            cmd.idx_op = IDX_INC;
            if (stat.rem_last) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = ST_SCAN_START;
            end
         end
         // swap one pair from both ends
         ST_REV_RD_A: begin
            cmd.rd_sel = RA_IDX;
            state_in   = ST_REV_RD_B;
         end
         ST_REV_RD_B: begin
            cmd.rd_sel = RA_JDX;
            cmd.tmp_ld = 1'b1;
            state_in   = ST_REV_WR_A;
         end
         ST_REV_WR_A: begin
            cmd.rd_sel = RA_JDX;
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            state_in   = ST_REV_WR_B;
         end
         ST_REV_WR_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_JDX;
            cmd.wd_sel = WD_TMP;
            cmd.idx_op = IDX_INC;
            cmd.jdx_op = JDX_DEC;
            state_in   = stat.rev_more ? ST_REV_RD_A : ST_SCAN_START;
         end
         // min and max walk over the stored words
         ST_SCAN_START: begin
            cmd.ext_init = 1'b1;
            cmd.idx_op   = IDX_ZERO;
            state_in     = stat.cnt_zero ? ST_FINISH : ST_SCAN_RUN;
         end
         ST_SCAN_RUN: begin
            cmd.rd_sel  = RA_IDX;
            cmd.scan_rd = 1'b1;
            cmd.idx_op  = IDX_INC;
            if (stat.scan_last) begin
               state_in = ST_SCAN_DRAIN;
            end
         end
         ST_SCAN_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/ale_dp.sv]
// list storage, pointers, extremes and result register
module ale_dp #(
   parameter int CAPACITY   = ale_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ale_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [ale_pkg::VALUE_W-1:0]   req_value,
   input  logic [ale_pkg::POS_W-1:0]            req_position,
   input  logic [ale_pkg::LEN_W-1:0]            cap_value,
   input  ale_pkg::ctrl_cmd_type                cmd,
   output ale_pkg::dp_stat_type                 stat,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [ale_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ale_pkg::LEN_W-1:0]            rsp_fill_length,
   output logic signed [ale_pkg::VALUE_W-1:0]   rsp_smallest,
   output logic signed [ale_pkg::VALUE_W-1:0]   rsp_largest
);
   import ale_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > LEN_W) ? CW : LEN_W) + 1;

   localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // request fields
   logic [MODE_W-1:0]              mode_ff;
   logic signed [DATA_WIDTH-1:0]   val_ff;
   logic [POS_W-1:0]               pos_ff;

   // list state and walk pointers
   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [AW-1:0]                  jdx_ff, jdx_in;
   logic signed [DATA_WIDTH-1:0]   tmp_ff;
   logic signed [DATA_WIDTH-1:0]   lo_ff, lo_in;
   logic signed [DATA_WIDTH-1:0]   hi_ff, hi_in;
   logic                           scan_vld_ff;
   status_type                     status_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]            rsp_status_ff;
   logic [LEN_W-1:0]               rsp_fill_length_ff;
   logic signed [VALUE_W-1:0]      rsp_smallest_ff;
   logic signed [VALUE_W-1:0]      rsp_largest_ff;

   // memory ports
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [DATA_WIDTH-1:0]          wr_data;
   logic [AW-1:0]                  rd_addr;
   logic signed [DATA_WIDTH-1:0]   rd_word;

   ale_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // status toward the controller
   always_comb begin
      stat.mode       = mode_ff;
      stat.pos_ok     = XW'(pos_ff) < XW'(count_ff);
      stat.has_room   = (XW'(count_ff) < XW'(cap_value)) && (count_ff < CW'(CAPACITY));
      stat.cnt_le1    = count_ff <= CW'(1);
      stat.rem_direct = (XW'(pos_ff) + XW'(1)) == XW'(count_ff);
      stat.ins_last   = XW'(idx_ff) == (XW'(pos_ff) + XW'(1));
      stat.rem_last   = (XW'(idx_ff) + XW'(2)) == XW'(count_ff);
      stat.rev_more   = (XW'(idx_ff) + XW'(2)) < XW'(jdx_ff);
      stat.scan_last  = (XW'(idx_ff) + XW'(1)) == XW'(count_ff);
      stat.cnt_zero   = count_ff == '0;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // read address decode
   always_comb begin
      unique case (cmd.rd_sel)
         RA_IDX:     rd_addr = idx_ff;
         RA_IDX_DN:  rd_addr = idx_ff - AW'(1);
         RA_IDX_DN2: rd_addr = idx_ff - AW'(2);
         RA_IDX_UP:  rd_addr = idx_ff + AW'(1);
         RA_IDX_UP2: rd_addr = idx_ff + AW'(2);
         RA_JDX:     rd_addr = jdx_ff;
         default:    rd_addr = idx_ff;
      endcase
   end

   // write address and data decode
   always_comb begin
      wr_en = cmd.wr_en;
      unique case (cmd.wa_sel)
         WA_COUNT: wr_addr = AW'(count_ff);
         WA_IDX:   wr_addr = idx_ff;
         WA_JDX:   wr_addr = jdx_ff;
         WA_POS:   wr_addr = AW'(pos_ff);
         default:  wr_addr = idx_ff;
      endcase
      unique case (cmd.wd_sel)
         WD_VALUE: wr_data = val_ff;
         WD_RDATA: wr_data = rd_word;
         WD_TMP:   wr_data = tmp_ff;
         default:  wr_data = val_ff;
      endcase
   end

   // pointer and length updates
   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_COUNT: idx_in = AW'(count_ff);
         IDX_POS:   idx_in = AW'(pos_ff);
         IDX_ZERO:  idx_in = '0;
         IDX_INC:   idx_in = idx_ff + AW'(1);
         IDX_DEC:   idx_in = idx_ff - AW'(1);
         default:   idx_in = idx_ff;
      endcase
      unique case (cmd.jdx_op)
         JDX_HOLD: jdx_in = jdx_ff;
         JDX_LAST: jdx_in = AW'(count_ff - CW'(1));
         JDX_DEC:  jdx_in = jdx_ff - AW'(1);
         default:  jdx_in = jdx_ff;
      endcase
      unique case (cmd.cnt_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   // running minimum and maximum
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.ext_init) begin
         lo_in = WORD_MAX;
         hi_in = WORD_MIN;
      end else if (scan_vld_ff) begin
         if (rd_word < lo_ff) begin
            lo_in = rd_word;
         end
         if (rd_word > hi_ff) begin
            hi_in = rd_word;
         end
      end
   end

   // result handshake
   always_comb begin
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_vld_ff  <= cmd.scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      jdx_ff <= jdx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (cmd.req_ld) begin
         mode_ff <= req_mode;
         val_ff  <= DATA_WIDTH'(req_value);
         pos_ff  <= req_position;
      end
      if (cmd.tmp_ld) begin
         tmp_ff <= rd_word;
      end
      if (cmd.status_ld) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.out_ld) begin
         rsp_status_ff      <= status_ff;
         rsp_fill_length_ff <= LEN_W'(count_ff);
         rsp_smallest_ff    <= VALUE_W'(lo_ff);
         rsp_largest_ff     <= VALUE_W'(hi_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fill_length = rsp_fill_length_ff;
   assign rsp_smallest    = rsp_smallest_ff;
   assign rsp_largest     = rsp_largest_ff;

endmodule

[sv/array_list_engine.sv]
// Append, clear and a rejected request go straight to the min/max walk over the stored words;
// insert first shifts the entries from the position up, remove shifts those above it down,
// reverse swaps pairs from both ends; the walk reads one word per cycle from the single read port.
// One request at a time: a new request is taken only in idle, after the result is loaded.
// Reset: synchronous; length zero, capacity register 64, result channel empty.
// The word memory is not cleared; only entries below the length reach a result.
module array_list_engine #(
   parameter int CAPACITY   = ale_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ale_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [ale_pkg::VALUE_W-1:0]   req_value,
   input  logic [ale_pkg::POS_W-1:0]            req_position,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ale_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ale_pkg::LEN_W-1:0]            rsp_fill_length,
   output logic signed [ale_pkg::VALUE_W-1:0]   rsp_smallest,
   output logic signed [ale_pkg::VALUE_W-1:0]   rsp_largest,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ale_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ale_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ale_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import ale_pkg::*;

   logic [LEN_W-1:0]     cap_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;
   ctrl_cmd_type         cmd;
   dp_stat_type          stat;

   // register decode
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready && (csr_idx == CSR_CAPACITY);
   assign prdata  = (csr_idx == CSR_CAPACITY) ? CSR_DATA_W'(cap_ff) : '0;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr) begin
         cap_ff <= pwdata[LEN_W-1:0];
      end
   end

   ale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ale_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .cap_value       (cap_ff),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_fill_length (rsp_fill_length),
      .rsp_smallest    (rsp_smallest),
      .rsp_largest     (rsp_largest)
   );

endmodule

[sv/ale_checker.sv]
// port-level checks of the array list engine and their binding
`include "assert_macros.svh"

module ale_checker #(
   parameter int CAPACITY   = ale_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic [ale_pkg::STATUS_W-1:0]       rsp_status,
   input logic [ale_pkg::LEN_W-1:0]          rsp_fill_length,
   input logic signed [ale_pkg::VALUE_W-1:0] rsp_smallest,
   input logic signed [ale_pkg::VALUE_W-1:0] rsp_largest
);
   import ale_pkg::*;

   // the engine is busy right after it takes a request
   `ALE_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request not followed by busy")

   // status is one of the defined codes
   `ALE_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status <= STAT_RANGE, "undefined status code")

   // a non-empty list has ordered extremes
   `ALE_ASSERT_IMP(a_extremes_order, clock, reset, rsp_valid && (rsp_fill_length != '0), rsp_smallest <= rsp_largest, "minimum above maximum")

   // length never exceeds the built capacity
   `ALE_ASSERT_IMP(a_length_bound, clock, reset, rsp_valid, int'(rsp_fill_length) <= CAPACITY, "length beyond capacity")

endmodule

bind array_list_engine ale_checker #(
   .CAPACITY   (CAPACITY),
   .DATA_WIDTH (DATA_WIDTH)
) u_ale_checker (.*);
